// ----- rtl/quadratic_curve_rasterizer_unit_macros.svh -----
// Assertion macros for the quadratic curve rasterizer
`ifndef QUADRATIC_CURVE_RASTERIZER_UNIT_MACROS_SVH
`define QUADRATIC_CURVE_RASTERIZER_UNIT_MACROS_SVH
`ifndef SYNTH
`define QCR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("qcr: assertion failed");
`define QCR_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("qcr: assertion failed");
`else
`define QCR_ASSERT_IMP(label, clk, rst, ante, cons)
`define QCR_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/qcr_pkg.sv -----
// Types and constants shared by the quadratic curve rasterizer
`timescale 1ns / 1ps
package qcr_pkg;
   localparam int COORD_BITS = 12;
   localparam int LEN_FRAC   = 8;
   localparam int LEN_BITS   = COORD_BITS + 1 + LEN_FRAC;
   localparam int IDX_BITS   = LEN_BITS - LEN_FRAC;
   localparam int D2_BITS    = 2 * COORD_BITS + 1;

   localparam logic KIND_START = 1'b0;
   localparam logic KIND_TICK  = 1'b1;

   typedef struct packed {
      logic                         kind;
      logic signed [COORD_BITS-1:0] start_x;
      logic signed [COORD_BITS-1:0] start_y;
      logic signed [COORD_BITS-1:0] end_x;
      logic signed [COORD_BITS-1:0] end_y;
      logic signed [COORD_BITS-1:0] ctrl_x;
      logic signed [COORD_BITS-1:0] ctrl_y;
      logic                         straight;
   } req_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] pixel_x;
      logic signed [COORD_BITS-1:0] pixel_y;
      logic                         last;
   } rsp_type;

   // classified word between front and back; control point is kept doubled
   typedef struct packed {
      logic                         is_start;
      logic signed [COORD_BITS-1:0] ax;
      logic signed [COORD_BITS-1:0] ay;
      logic signed [COORD_BITS-1:0] bx;
      logic signed [COORD_BITS-1:0] by;
      logic signed [COORD_BITS:0]   cx2;
      logic signed [COORD_BITS:0]   cy2;
      logic        [COORD_BITS-1:0] dx;
      logic        [COORD_BITS-1:0] dy;
   } cmd_type;
endpackage

// ----- rtl/quadratic_curve_rasterizer_unit.sv -----
// Top level of the quadratic curve rasterizer
//
//   channel   ports                        direction  word
//   request   req_push req_full req_data   in         req_type
//   response  rsp_empty rsp_pop rsp_data   out        rsp_type
//
// A start word in the back end is taken from the queue, then its squared distance is
// formed on the shared multiplier, then the bit-serial square root runs.
// A tick is taken from the queue, then runs through the serial step divider, the blend
// of both axes on the one multiplier, and a final step that loads the result;
// that last step waits while an earlier result sits unread.
// Synchronous active-high reset; the two-entry queue keeps taking words while
// the back end works or a result waits on rsp_data.
`timescale 1ns / 1ps
module quadratic_curve_rasterizer_unit import qcr_pkg::*; #(
   parameter int T_FRAC_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);
   cmd_type cmd_in, cmd_out;
   logic    cmd_pop, cmd_empty;

   qcr_front u_front (
      .req_word (req_data),
      .cmd_word (cmd_in)
   );

   qcr_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_word (cmd_in),
      .full      (req_full),
      .pop       (cmd_pop),
      .pop_word  (cmd_out),
      .empty     (cmd_empty)
   );

   qcr_back #(
      .T_FRAC_BITS (T_FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_word  (cmd_out),
      .cmd_pop   (cmd_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );
endmodule

// ----- rtl/qcr_front.sv -----
// Front end: decodes an input word into a command word
`timescale 1ns / 1ps
module qcr_front import qcr_pkg::*; (
   input  req_type req_word,
   output cmd_type cmd_word
);
   logic signed [COORD_BITS:0] ax_e, ay_e, bx_e, by_e;
   logic signed [COORD_BITS:0] dx_s, dy_s;
   logic signed [COORD_BITS:0] dx_m, dy_m;

   always_comb begin
      ax_e = (COORD_BITS+1)'(req_word.start_x);
      ay_e = (COORD_BITS+1)'(req_word.start_y);
      bx_e = (COORD_BITS+1)'(req_word.end_x);
      by_e = (COORD_BITS+1)'(req_word.end_y);
      dx_s = ax_e - bx_e;
      dy_s = ay_e - by_e;
      dx_m = dx_s[COORD_BITS] ? -dx_s : dx_s;
      dy_m = dy_s[COORD_BITS] ? -dy_s : dy_s;
      cmd_word.is_start = (req_word.kind == KIND_START);
      cmd_word.ax = req_word.start_x;
      cmd_word.ay = req_word.start_y;
      cmd_word.bx = req_word.end_x;
      cmd_word.by = req_word.end_y;
      if (req_word.straight) begin
         cmd_word.cx2 = ax_e + bx_e;
         cmd_word.cy2 = ay_e + by_e;
      end else begin
         cmd_word.cx2 = {req_word.ctrl_x, 1'b0};
         cmd_word.cy2 = {req_word.ctrl_y, 1'b0};
      end
      cmd_word.dx = dx_m[COORD_BITS-1:0];
      cmd_word.dy = dy_m[COORD_BITS-1:0];
   end
endmodule

// ----- rtl/qcr_fifo.sv -----
// Two-entry command queue between front and back
`timescale 1ns / 1ps
module qcr_fifo import qcr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_word,
   output logic    full,
   input  logic    pop,
   output cmd_type pop_word,
   output logic    empty
);
   localparam int DEPTH = 2;
   localparam int PTR_BITS = 1;
   localparam int CNT_BITS = 2;

   cmd_type               mem_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  wr_en, rd_en;

   always_comb begin
      full = (count_ff == CNT_BITS'(DEPTH));
      empty = (count_ff == '0);
      wr_en = push && !full;
      rd_en = pop && !empty;
      pop_word = mem_ff[rd_ptr_ff];
      wr_ptr_in = wr_en ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = rd_en ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff + CNT_BITS'(wr_en) - CNT_BITS'(rd_en);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= push_word;
      end
   end
endmodule

// ----- rtl/qcr_back.sv -----
// Back end: length square root, step divider, blend sequencer, result register
`timescale 1ns / 1ps
`include "quadratic_curve_rasterizer_unit_macros.svh"
module qcr_back import qcr_pkg::*; #(
   parameter int T_FRAC_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_empty,
   input  cmd_type cmd_word,
   output logic    cmd_pop,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);
   localparam int TF = T_FRAC_BITS;
   localparam int MA = (TF + 1 > COORD_BITS) ? TF + 1 : COORD_BITS;
   localparam int MB = TF + 14;
   localparam int PW = MA + 1 + MB;
   localparam int REM_BITS = LEN_BITS + 3;
   localparam int V_BITS = 2 * LEN_BITS;
   localparam int CNT_BITS = $clog2(((TF > LEN_BITS) ? TF : LEN_BITS) + 1);
   localparam logic [CNT_BITS-1:0] CNT_ONE = CNT_BITS'(1);
   localparam logic signed [PW-1:0] BIAS = PW'((64'd1 << (2 * TF)) - 64'd1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SQ0  = 3'd1;
   localparam logic [2:0] S_SQ1  = 3'd2;
   localparam logic [2:0] S_ROOT = 3'd3;
   localparam logic [2:0] S_DIV  = 3'd4;
   localparam logic [2:0] S_MIX  = 3'd5;
   localparam logic [2:0] S_OUT  = 3'd6;

   localparam logic [2:0] STEP_UA    = 3'd0;
   localparam logic [2:0] STEP_TC    = 3'd1;
   localparam logic [2:0] STEP_TB    = 3'd2;
   localparam logic [2:0] STEP_UX    = 3'd3;
   localparam logic [2:0] STEP_TY    = 3'd4;
   localparam logic [2:0] STEP_ROUND = 3'd5;

   logic [2:0]                   state_ff;
   logic [2:0]                   step_ff;
   logic                         axis_ff;
   logic signed [COORD_BITS-1:0] ax_ff, ay_ff, bx_ff, by_ff;
   logic signed [COORD_BITS:0]   cx_ff, cy_ff;
   logic [COORD_BITS-1:0]        dx_ff, dy_ff;
   logic [LEN_BITS-1:0]          len_ff;
   logic [IDX_BITS-1:0]          idx_ff;
   logic                         drawing_ff;
   logic [CNT_BITS-1:0]          cnt_ff;
   logic [D2_BITS-1:0]           d2_ff;
   logic [V_BITS-1:0]            v_ff;
   logic [REM_BITS-1:0]          rem_ff;
   logic [LEN_BITS-1:0]          root_ff;
   logic [LEN_BITS-1:0]          div_rem_ff;
   logic [TF-1:0]                q_ff;
   logic signed [MB-1:0]         xw_ff, yw_ff;
   logic signed [PW-1:0]         acc_ff;
   logic signed [COORD_BITS-1:0] pix_x_ff, pix_y_ff;
   logic                         last_ff;
   logic                         out_valid_ff;
   rsp_type                      out_ff;

   logic [TF:0]                  u_w;
   logic [MA-1:0]                mul_a;
   logic signed [MB-1:0]         mul_b;
   logic signed [PW-1:0]         mul_p;
   logic signed [COORD_BITS-1:0] a_sel, b_sel;
   logic signed [COORD_BITS:0]   c_sel;
   logic [REM_BITS-1:0]          rem_sh, trial;
   logic                         root_ge;
   logic [LEN_BITS-1:0]          root_next;
   logic [LEN_BITS:0]            dshift;
   logic                         div_ge;
   logic [LEN_BITS:0]            div_diff;
   logic [IDX_BITS:0]            idx_inc;
   logic [LEN_BITS:0]            inc_scaled;
   logic                         is_last;
   logic [LEN_BITS-1:0]          idx_scaled;
   logic signed [PW-1:0]         acc_adj;
   logic signed [PW-1:0]         acc_shift;
   logic [D2_BITS-1:0]           d2_sum;
   logic                         out_free;

   always_comb begin
      u_w = {1'b1, {TF{1'b0}}} - {1'b0, q_ff};
      a_sel = axis_ff ? ay_ff : ax_ff;
      b_sel = axis_ff ? by_ff : bx_ff;
      c_sel = axis_ff ? cy_ff : cx_ff;
      mul_a = MA'(dx_ff);
      mul_b = MB'(dx_ff);
      case (state_ff)
         S_SQ1: begin
            mul_a = MA'(dy_ff);
            mul_b = MB'(dy_ff);
         end
         S_MIX: begin
            case (step_ff)
               STEP_UA: begin
                  mul_a = MA'(u_w);
                  mul_b = MB'(a_sel);
               end
               STEP_TC: begin
                  mul_a = MA'(q_ff);
                  mul_b = MB'(c_sel);
               end
               STEP_TB: begin
                  mul_a = MA'(q_ff);
                  mul_b = MB'(b_sel);
               end
               STEP_UX: begin
                  mul_a = MA'(u_w);
                  mul_b = xw_ff;
               end
               STEP_TY: begin
                  mul_a = MA'(q_ff);
                  mul_b = yw_ff;
               end
               default: begin
                  mul_a = MA'(q_ff);
                  mul_b = yw_ff;
               end
            endcase
         end
         default: begin
            mul_a = MA'(dx_ff);
            mul_b = MB'(dx_ff);
         end
      endcase
      mul_p = $signed({1'b0, mul_a}) * mul_b;

      rem_sh = {rem_ff[REM_BITS-3:0], v_ff[V_BITS-1 -: 2]};
      trial = REM_BITS'({root_ff, 2'b01});
      root_ge = rem_sh >= trial;
      root_next = {root_ff[LEN_BITS-2:0], root_ge};

      dshift = {div_rem_ff, 1'b0};
      div_ge = dshift >= {1'b0, len_ff};
      div_diff = dshift - {1'b0, len_ff};

      idx_inc = {1'b0, idx_ff} + 1'b1;
      inc_scaled = {idx_inc, {LEN_FRAC{1'b0}}};
      is_last = inc_scaled >= {1'b0, len_ff};
      idx_scaled = {idx_ff, {LEN_FRAC{1'b0}}};

      acc_adj = acc_ff + (acc_ff[PW-1] ? BIAS : PW'(0));
      acc_shift = acc_adj >>> (2 * TF);
      d2_sum = d2_ff + D2_BITS'(mul_p);

      out_free = !out_valid_ff || rsp_pop;
      cmd_pop = (state_ff == S_IDLE) && !cmd_empty;
      rsp_empty = !out_valid_ff;
      rsp_data = out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff <= STEP_UA;
         axis_ff <= 1'b0;
         len_ff <= '0;
         idx_ff <= '0;
         drawing_ff <= 1'b0;
         cnt_ff <= '0;
         out_valid_ff <= 1'b0;
         ax_ff <= '0;
         ay_ff <= '0;
         bx_ff <= '0;
         by_ff <= '0;
         cx_ff <= '0;
         cy_ff <= '0;
      end else begin
         if (rsp_pop && !(state_ff == S_OUT && out_free)) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (!cmd_empty) begin
                  if (cmd_word.is_start) begin
                     ax_ff <= cmd_word.ax;
                     ay_ff <= cmd_word.ay;
                     bx_ff <= cmd_word.bx;
                     by_ff <= cmd_word.by;
                     cx_ff <= cmd_word.cx2;
                     cy_ff <= cmd_word.cy2;
                     dx_ff <= cmd_word.dx;
                     dy_ff <= cmd_word.dy;
                     drawing_ff <= 1'b0;
                     state_ff <= S_SQ0;
                  end else if (drawing_ff) begin
                     div_rem_ff <= idx_scaled;
                     q_ff <= '0;
                     cnt_ff <= CNT_BITS'(TF);
                     last_ff <= is_last;
                     state_ff <= S_DIV;
                  end
               end
            end
            S_SQ0: begin
               d2_ff <= D2_BITS'(mul_p);
               state_ff <= S_SQ1;
            end
            S_SQ1: begin
               v_ff <= V_BITS'({d2_sum, {(2 * LEN_FRAC){1'b0}}});
               rem_ff <= '0;
               root_ff <= '0;
               cnt_ff <= CNT_BITS'(LEN_BITS);
               state_ff <= S_ROOT;
            end
            S_ROOT: begin
               rem_ff <= root_ge ? rem_sh - trial : rem_sh;
               root_ff <= root_next;
               v_ff <= v_ff << 2;
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == CNT_ONE) begin
                  len_ff <= root_next;
                  drawing_ff <= (root_next != '0);
                  idx_ff <= '0;
                  state_ff <= S_IDLE;
               end
            end
            S_DIV: begin
               div_rem_ff <= div_ge ? div_diff[LEN_BITS-1:0] : dshift[LEN_BITS-1:0];
               q_ff <= {q_ff[TF-2:0], div_ge};
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == CNT_ONE) begin
                  step_ff <= STEP_UA;
                  axis_ff <= 1'b0;
                  state_ff <= S_MIX;
               end
            end
            S_MIX: begin
               case (step_ff)
                  STEP_UA: begin
                     xw_ff <= MB'(mul_p);
                     step_ff <= STEP_TC;
                  end
                  STEP_TC: begin
                     xw_ff <= xw_ff + MB'(mul_p);
                     step_ff <= STEP_TB;
                  end
                  STEP_TB: begin
                     yw_ff <= MB'(mul_p);
                     step_ff <= STEP_UX;
                  end
                  STEP_UX: begin
                     acc_ff <= mul_p;
                     step_ff <= STEP_TY;
                  end
                  STEP_TY: begin
                     acc_ff <= acc_ff + mul_p;
                     step_ff <= STEP_ROUND;
                  end
                  STEP_ROUND: begin
                     step_ff <= STEP_UA;
                     if (axis_ff) begin
                        pix_y_ff <= acc_shift[COORD_BITS-1:0];
                        state_ff <= S_OUT;
                     end else begin
                        pix_x_ff <= acc_shift[COORD_BITS-1:0];
                        axis_ff <= 1'b1;
                     end
                  end
                  default: step_ff <= STEP_UA;
               endcase
            end
            S_OUT: begin
               if (out_free) begin
                  out_ff <= '{pixel_x: pix_x_ff, pixel_y: pix_y_ff, last: last_ff};
                  out_valid_ff <= 1'b1;
                  if (last_ff) begin
                     drawing_ff <= 1'b0;
                     idx_ff <= '0;
                  end else begin
                     idx_ff <= idx_ff + 1'b1;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `QCR_ASSERT_IMP(a_draw_in_range, clock, reset, drawing_ff, idx_scaled < len_ff)
   `QCR_ASSERT_IMP(a_div_rem_below_len, clock, reset, state_ff == S_DIV, div_rem_ff < len_ff)
   `QCR_ASSERT_NXT(a_root_sets_draw, clock, reset, state_ff == S_ROOT && cnt_ff == CNT_ONE, drawing_ff == (len_ff != '0))
   `QCR_ASSERT_IMP(a_mix_step_range, clock, reset, state_ff == S_MIX, step_ff <= STEP_ROUND)
endmodule
